[sv/mlf_pkg.sv]
package mlf_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int PORT_COUNT  = 8;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int PORT_W = 4;
	localparam int MAC_W  = 48;
	localparam int MASK_W = 8;

	localparam logic [MASK_W-1:0] ALL_PORTS = MASK_W'((1 << PORT_COUNT) - 1);

	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic [MAC_W-1:0]  mac;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           entry;
	} tbl_wr_t;

	// one-hot bit for ports 1..PORT_COUNT, nothing for any other code
	function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] p);
		logic [MASK_W-1:0] r;
		r = '0;
		for (int i = 0; i < PORT_COUNT; i++) begin
			if (p == PORT_W'(i + 1)) begin
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [MASK_W-1:0] flood_mask(input logic [PORT_W-1:0] p);
		return ALL_PORTS & ~port_bit(p);
	endfunction

endpackage

[sv/mac_learning_forwarding_top.sv]
// Learning bridge MAC table. Each input transfer is one frame (ingress port,
// destination and source MAC); each produces exactly one output transfer with
// the forwarding mask and the learn flags. The table lives in one synchronous
// memory and is walked one entry per cycle, so a frame's result is registered
// once every entry currently held (at most 64 with a full 64-entry table) has
// been read, and the block passes back through idle before the next frame is
// taken. One frame is in flight at a time;
// a finished result may sit in the output register while the next frame is
// already accepted and walking the table. Entries are appended in arrival
// order and never aged out; once the table is full, unknown sources are
// flagged in learn_dropped and not stored.
module mac_learning_forwarding_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mlf_pkg::PORT_W-1:0]  in_port,
	input  logic [mlf_pkg::MAC_W-1:0]   dst_mac,
	input  logic [mlf_pkg::MAC_W-1:0]   src_mac,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mlf_pkg::MASK_W-1:0]  forward_mask,
	output logic                        is_broadcast,
	output logic                        learned_new,
	output logic                        learn_dropped
);
	import mlf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LEARN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;   // entries held
	logic [CNT_W-1:0]  rd_cnt_q;  // next entry to read
	logic              rd_vld_s1; // read data of the previous cycle is valid
	logic              known_q;   // source already learned on this port
	logic              hit_q;     // some entry matched the destination
	logic [MASK_W-1:0] mask_q;    // ports of matching entries
	logic              out_valid_q;

	// captured frame
	logic [PORT_W-1:0] port_q;
	logic [MAC_W-1:0]  dst_q;
	logic [MAC_W-1:0]  src_q;

	// result payload
	logic [MASK_W-1:0] fwd_q;
	logic              bcast_q;
	logic              learned_q;
	logic              dropped_q;

	tbl_rd_t rd;
	tbl_wr_t wr;
	entry_t  rd_data;

	logic              accept;
	logic              out_free;
	logic              emit;
	logic              room;
	logic              learn;
	logic              drop;
	logic              self_hit;
	logic              hit_f;
	logic [MASK_W-1:0] mask_f;

	mlf_table u_table (
		.clk     (clk),
		.rd      (rd),
		.wr      (wr),
		.rd_data (rd_data)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (state_q == ST_LEARN) && out_free;

	// walk entries 0..n-1, one read issued per cycle
	assign rd.en   = (state_q == ST_SCAN) && (rd_cnt_q != count_q);
	assign rd.addr = rd_cnt_q[IDX_W-1:0];

	// learning decision once the walk is done; the new entry also takes part
	// in forwarding, so a frame sent to itself goes back out its ingress port
	assign room     = (count_q != CNT_W'(TABLE_DEPTH));
	assign learn    = !known_q && room;
	assign drop     = !known_q && !room;
	assign self_hit = learn && (dst_q == src_q);
	assign hit_f    = hit_q || self_hit;
	assign mask_f   = hit_f ? (mask_q | (self_hit ? port_bit(port_q) : '0))
	                        : flood_mask(port_q);

	// append only on the cycle the result is taken into the output register
	assign wr.en         = emit && learn;
	assign wr.addr       = count_q[IDX_W-1:0];
	assign wr.entry.port = port_q;
	assign wr.entry.mac  = src_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			known_q     <= 1'b0;
			hit_q       <= 1'b0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one being taken in the same cycle
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cnt_q  <= '0;
						rd_vld_s1 <= 1'b0;
						known_q   <= 1'b0;
						hit_q     <= 1'b0;
						mask_q    <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1) begin
						if (rd_data.port == port_q && rd_data.mac == src_q) begin
							known_q <= 1'b1;
						end
						if (rd_data.mac == dst_q) begin
							hit_q  <= 1'b1;
							mask_q <= mask_q | port_bit(rd_data.port);
						end
					end
					rd_vld_s1 <= rd.en;
					if (rd.en) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end else begin
						state_q <= ST_LEARN;
					end
				end
				ST_LEARN: begin
					if (out_free) begin
						if (learn) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			port_q <= in_port;
			dst_q  <= dst_mac;
			src_q  <= src_mac;
		end
		if (emit) begin
			fwd_q     <= mask_f;
			bcast_q   <= !hit_f;
			learned_q <= learn;
			dropped_q <= drop;
		end
	end

	assign out_valid     = out_valid_q;
	assign forward_mask  = fwd_q;
	assign is_broadcast  = bcast_q;
	assign learned_new   = learned_q;
	assign learn_dropped = dropped_q;

`ifndef ASSERT_OFF
	// fill count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// the walk never reads past the filled part of the table
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= count_q))
		else $error("table walk beyond fill count");

	// a dropped learn only happens with a full table, which then stays full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dropped_q) |-> (count_q == CNT_W'(TABLE_DEPTH)))
		else $error("learn dropped with room in table");

	// a result never reports both an append and a drop
	a_learn_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(learned_q && dropped_q))
		else $error("learned and dropped together");
`endif

endmodule

[sv/mlf_table.sv]
module mlf_table (
	input  logic            clk,
	input  mlf_pkg::tbl_rd_t rd,
	input  mlf_pkg::tbl_wr_t wr,
	output mlf_pkg::entry_t  rd_data
);
	import mlf_pkg::*;

	entry_t mem_q [TABLE_DEPTH];
	entry_t rdata_s1;

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.entry;
		end
		if (rd.en) begin
			rdata_s1 <= mem_q[rd.addr];
		end
	end

	assign rd_data = rdata_s1;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the learning bridge MAC table.
// A short table of hand-picked frames comes first, then random frames drawn
// mostly from a small pool of addresses so that sources repeat, destinations
// hit and the table fills up and starts to drop new entries. Every accepted
// frame is run through a bench-side model of the table; its decision (or a
// row's typed-in result) is queued and compared with the next result transfer.
module tb_top;
	import mlf_pkg::*;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic              bcast;
		logic              learned;
		logic              dropped;
	} fwd_result_t;

	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic [MAC_W-1:0]  dst;
		logic [MAC_W-1:0]  src;
		logic              typed;
		fwd_result_t       want;
	} frame_row_t;

	localparam logic        TYPED_IN    = 1'b1;
	localparam logic        PREDICTED   = 1'b0;
	localparam fwd_result_t NO_RESULT   = '0;
	localparam int          N_ROWS      = 19;
	localparam int          RANDOM_FRAMES = 630;
	localparam int          PHASE_LEN   = 217;   // frames per idling phase
	localparam int          POOL_SIZE   = 12;
	localparam int          PRESSURE_AT = 300;   // results seen before the long hold
	localparam int          HOLD_CYCLES = 400;
	localparam int          DRAIN_CYCLES = 150;
	localparam int          LIMIT_NS    = 1_000_000;
	localparam int          MAX_REPORTS = 10;

	// Hand-picked frames. The first rows, easy to work out from an empty table,
	// and the last carry their result typed in; the rest go through the model.
	localparam frame_row_t DIRECTED_ROWS [N_ROWS] = '{
		// empty table, all-ones destination: flood to all but port 1
		'{4'd1,  48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, TYPED_IN, '{8'hFE, 1'b1, 1'b1, 1'b0}},
		// destination is the address just learned on port 1
		'{4'd8,  48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, TYPED_IN, '{8'h01, 1'b0, 1'b1, 1'b0}},
		// known source, destination equals source: back to port 8
		'{4'd8,  48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, TYPED_IN, '{8'h80, 1'b0, 1'b0, 1'b0}},
		// port 0 learned as given; flooding from it sets every port
		'{4'd0,  48'h0000_0000_00A5, 48'h1234_5678_9ABC, TYPED_IN, '{8'hFF, 1'b1, 1'b1, 1'b0}},
		// hit on an entry held by port 0: no flood, empty mask
		'{4'd15, 48'h1234_5678_9ABC, 48'h5555_5555_5555, TYPED_IN, '{8'h00, 1'b0, 1'b1, 1'b0}},
		'{4'd3,  48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, TYPED_IN, '{8'h04, 1'b0, 1'b1, 1'b0}},
		'{4'd9,  48'h5555_5555_5555, 48'h0000_0000_0001, PREDICTED, NO_RESULT},
		'{4'd2,  48'h0000_0000_0000, 48'h0000_0000_0000, PREDICTED, NO_RESULT},
		'{4'd4,  48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, PREDICTED, NO_RESULT},
		'{4'd5,  48'h0102_0304_0506, 48'h0A0B_0C0D_0E0F, PREDICTED, NO_RESULT},
		'{4'd6,  48'h0A0B_0C0D_0E0F, 48'h0102_0304_0506, PREDICTED, NO_RESULT},
		'{4'd7,  48'hAAAA_AAAA_AAAA, 48'h0A0B_0C0D_0E0F, PREDICTED, NO_RESULT},
		'{4'd1,  48'h0A0B_0C0D_0E0F, 48'h0000_0000_0000, PREDICTED, NO_RESULT},
		'{4'd10, 48'h8000_0000_0000, 48'h8000_0000_0000, PREDICTED, NO_RESULT},
		'{4'd12, 48'h0000_0000_0001, 48'h7FFF_FFFF_FFFF, PREDICTED, NO_RESULT},
		'{4'd8,  48'h7FFF_FFFF_FFFF, 48'h0000_0000_0001, PREDICTED, NO_RESULT},
		'{4'd14, 48'hDEAD_BEEF_0000, 48'hDEAD_BEEF_0000, PREDICTED, NO_RESULT},
		'{4'd11, 48'h1234_5678_9ABC, 48'h0000_0000_0000, PREDICTED, NO_RESULT},
		// unknown destination from out-of-range port 13: every port
		'{4'd13, 48'hFEDC_BA98_7654, 48'h0000_0000_0000, TYPED_IN, '{8'hFF, 1'b1, 1'b1, 1'b0}}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [PORT_W-1:0] in_port = '0;
	logic [MAC_W-1:0]  dst_mac = '0;
	logic [MAC_W-1:0]  src_mac = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [MASK_W-1:0] forward_mask;
	logic              is_broadcast;
	logic              learned_new;
	logic              learn_dropped;

	// bench copy of the table
	logic [PORT_W-1:0] tbl_port [TABLE_DEPTH];
	logic [MAC_W-1:0]  tbl_mac [TABLE_DEPTH];
	int                tbl_held = 0;

	fwd_result_t pending_decisions [$];
	int          frames_sent = 0;
	int          mismatches = 0;
	int          send_idle_pct = 16;
	int          recv_stall_pct = 50;

	mac_learning_forwarding_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_port       (in_port),
		.dst_mac       (dst_mac),
		.src_mac       (src_mac),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.forward_mask  (forward_mask),
		.is_broadcast  (is_broadcast),
		.learned_new   (learned_new),
		.learn_dropped (learn_dropped)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(LIMIT_NS);
		$display("mac_learning_forwarding_top regression: fail");
		$finish;
	end

	// ports outside 1..PORT_COUNT own no bit of the mask
	function automatic logic [MASK_W-1:0] port_onehot(input logic [PORT_W-1:0] p);
		if (p >= 1 && p <= PORT_COUNT) begin
			return MASK_W'(1) << (p - 1);
		end
		return '0;
	endfunction

	// learn the source first, then gather every entry matching the destination;
	// the search sees an entry this very frame added
	function automatic fwd_result_t learn_and_forward(input logic [PORT_W-1:0] port,
			input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src);
		fwd_result_t r;
		logic        known;
		r = '0;
		known = 1'b0;
		for (int k = 0; k < tbl_held; k++) begin
			if (tbl_port[k] == port && tbl_mac[k] == src) begin
				known = 1'b1;
			end
		end
		if (!known) begin
			if (tbl_held < TABLE_DEPTH) begin
				tbl_port[tbl_held] = port;
				tbl_mac[tbl_held] = src;
				tbl_held++;
				r.learned = 1'b1;
			end else begin
				r.dropped = 1'b1;
			end
		end
		r.bcast = 1'b1;
		for (int k = 0; k < tbl_held; k++) begin
			if (tbl_mac[k] == dst) begin
				r.bcast = 1'b0;
				r.mask |= port_onehot(tbl_port[k]);
			end
		end
		if (r.bcast) begin
			for (int p = 1; p <= PORT_COUNT; p++) begin
				if (p != port) begin
					r.mask |= port_onehot(PORT_W'(p));
				end
			end
		end
		return r;
	endfunction

	function automatic logic [MAC_W-1:0] any_mac();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Offer one frame and hold it until the transfer happens, then queue its
	// decision. A typed-in row still runs the model so the table stays in step.
	task automatic send_frame(input logic [PORT_W-1:0] port, input logic [MAC_W-1:0] dst,
			input logic [MAC_W-1:0] src, input logic typed, input fwd_result_t want);
		fwd_result_t predicted;
		in_valid <= 1'b1;
		in_port <= port;
		dst_mac <= dst;
		src_mac <= src;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted = learn_and_forward(port, dst, src);
		pending_decisions.push_back(typed ? want : predicted);
		frames_sent++;
		// idling phases: sender light / receiver heavy, then swapped, then none
		if (frames_sent == PHASE_LEN) begin
			send_idle_pct = 50;
			recv_stall_pct <= 16;
		end else if (frames_sent == 2 * PHASE_LEN) begin
			send_idle_pct = 0;
			recv_stall_pct <= 0;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stimulus and end of run
	initial begin
		logic [MAC_W-1:0]  mac_pool [POOL_SIZE];
		logic [MAC_W-1:0]  src;
		logic [MAC_W-1:0]  dst;
		logic [MAC_W-1:0]  last_src;
		logic [PORT_W-1:0] port;
		int                roll;
		for (int i = 0; i < POOL_SIZE; i++) begin
			mac_pool[i] = any_mac();
		end
		last_src = mac_pool[0];
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			send_frame(DIRECTED_ROWS[i].port, DIRECTED_ROWS[i].dst, DIRECTED_ROWS[i].src,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end

		// Small pool of sources over mostly legal ports: pairs repeat often
		// enough to hit known entries, yet there are more than the table holds,
		// so it fills and later new pairs are dropped.
		for (int i = 0; i < RANDOM_FRAMES; i++) begin
			src = ($urandom_range(99) < 85) ? mac_pool[$urandom_range(POOL_SIZE - 1)] : any_mac();
			if ($urandom_range(99) < 80) begin
				port = PORT_W'($urandom_range(PORT_COUNT, 1));
			end else begin
				port = PORT_W'($urandom_range((1 << PORT_W) - 1));
			end
			roll = $urandom_range(99);
			if (roll < 60) begin
				dst = mac_pool[$urandom_range(POOL_SIZE - 1)];
			end else if (roll < 75) begin
				dst = last_src;
			end else if (roll < 85) begin
				dst = src;
			end else begin
				dst = any_mac();
			end
			last_src = src;
			send_frame(port, dst, src, PREDICTED, NO_RESULT);
		end
		in_valid <= 1'b0;

		while (pending_decisions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_decisions.size() == 0) begin
			$display("mac_learning_forwarding_top regression: pass");
		end else begin
			$display("mac_learning_forwarding_top regression: fail");
		end
		$finish;
	end

	// Result side: check each transfer against the oldest decision, then pick
	// the stall for the next cycle. Once PRESSURE_AT results are in, the stall
	// is held for a long stretch so the block backs up and stalls its input.
	initial begin
		fwd_result_t got;
		fwd_result_t want;
		int          results_seen;
		int          hold_left;
		logic        pressure_done;
		results_seen = 0;
		hold_left = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got = '{forward_mask, is_broadcast, learned_new, learn_dropped};
				if (pending_decisions.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("unexpected transfer: mask %h bcast %b learned %b dropped %b",
							got.mask, got.bcast, got.learned, got.dropped);
					end
				end else begin
					want = pending_decisions.pop_front();
					if (got.mask !== want.mask || got.bcast !== want.bcast ||
							got.learned !== want.learned || got.dropped !== want.dropped) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("result %0d: mask %h/%h bcast %b/%b learned %b/%b dropped %b/%b (exp/got)",
								results_seen, want.mask, got.mask, want.bcast, got.bcast,
								want.learned, got.learned, want.dropped, got.dropped);
						end
					end
				end
				results_seen++;
			end
			if (results_seen == PRESSURE_AT && !pressure_done) begin
				hold_left = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

endmodule
